[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Both expect clk_i and rst_ni to exist in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication check, same clocking and reset handling.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/plp_pkg.sv]
`default_nettype none

package plp_pkg;

  // list capacity
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // command codes
  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // per-cell update select
  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_LOAD      = 2'd1,
    OP_FROM_PREV = 2'd2,
    OP_FROM_NEXT = 2'd3
  } cell_op_e;

  // one list entry
  typedef struct packed {
    logic [31:0] code;
    logic [31:0] price;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/plp_cell.sv]
`default_nettype none

// One slot of the list: holds an entry, or takes the new one or a neighbor's.
module plp_cell (
  input  wire logic              clk_i,
  input  wire plp_pkg::cell_op_e op_i,
  input  wire plp_pkg::entry_t   new_i,
  input  wire plp_pkg::entry_t   prev_i,
  input  wire plp_pkg::entry_t   next_i,
  output plp_pkg::entry_t        entry_o
);

  plp_pkg::entry_t entry_q, entry_d;

  // next slot contents
  always_comb begin
    case (op_i)
      plp_pkg::OP_LOAD:      entry_d = new_i;
      plp_pkg::OP_FROM_PREV: entry_d = prev_i;
      plp_pkg::OP_FROM_NEXT: entry_d = next_i;
      default:               entry_d = entry_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[rtl/core/positional_array_list.sv]
// Positional list of up to DEPTH entries (item code + 32-bit price word).
// Input channel: in_valid_i / in_stall_o carry one request: command, 1-based
// position and, for insert, the new entry. Output channel: out_valid_o /
// out_stall_i carry one result per request: status, entry fields, count.
// A request is taken when valid is high and stall is low.
// The result is registered and presented in the cycle after the request is taken.
// Throughput: one request per cycle; every slot cell shifts in parallel, so
// insert and delete take no longer than a query. The limit is the single
// output register: while a result waits under out_stall_i, in_stall_o is
// raised and no new request is taken.
// Reset clears the entry count and the output valid; slot contents stay
// undefined and are only read after they were written.
// Failed requests (bad position, full list, unknown command) leave the list
// unchanged and return zero entry fields.
`default_nettype none

`include "assert_macros.svh"

module positional_array_list (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [4:0]         position_i,
  input  wire logic signed [31:0] new_code_i,
  input  wire logic [31:0]        new_price_bits_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      item_code_o,
  output logic [31:0]             item_price_bits_o,
  output logic [4:0]              entry_count_o
);

  localparam int unsigned CMP_W = ((plp_pkg::CNT_W > 5) ? plp_pkg::CNT_W : 5) + 1;

  plp_pkg::entry_t   cell_q   [plp_pkg::DEPTH];
  plp_pkg::cell_op_e cell_op  [plp_pkg::DEPTH];
  plp_pkg::entry_t   new_entry;

  logic [plp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      out_valid_q;
  plp_pkg::status_e          status_q, status_d;
  logic [31:0]               code_q, code_d;
  logic [31:0]               price_q, price_d;
  logic [4:0]                count_q;

  logic                      accept;
  logic [CMP_W-1:0]          pos_ext, cnt_ext, pos_m1;
  logic [plp_pkg::IDX_W-1:0] idx;
  logic                      pos_rd_ok, pos_ins_ok, full;
  logic                      do_ins, do_del;
  plp_pkg::entry_t           rd_entry;
  plp_pkg::cmd_e             cmd;

  assign accept    = in_valid_i && !in_stall_o;
  assign new_entry = '{code: new_code_i, price: new_price_bits_i};
  assign cmd       = plp_pkg::cmd_e'(command_i);

  // position checks against the current count
  assign pos_ext    = CMP_W'(position_i);
  assign cnt_ext    = CMP_W'(cnt_q);
  assign pos_m1     = pos_ext - CMP_W'(1);
  assign idx        = pos_m1[plp_pkg::IDX_W-1:0];
  assign full       = (cnt_ext >= CMP_W'(plp_pkg::DEPTH));
  assign pos_rd_ok  = (position_i != 5'd0) && (pos_ext <= cnt_ext);
  assign pos_ins_ok = (position_i != 5'd0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign rd_entry   = cell_q[idx];

  // command decode and result
  always_comb begin
    status_d = plp_pkg::ST_BADPOS;
    code_d   = '0;
    price_d  = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    unique case (cmd)
      plp_pkg::CMD_QUERY: begin
        if (pos_rd_ok) begin
          status_d = plp_pkg::ST_OK;
          code_d   = rd_entry.code;
          price_d  = rd_entry.price;
        end
      end
      plp_pkg::CMD_INSERT: begin
        if (full) begin
          status_d = plp_pkg::ST_FULL;
        end else if (pos_ins_ok) begin
          status_d = plp_pkg::ST_OK;
          do_ins   = 1'b1;
        end
      end
      plp_pkg::CMD_DELETE: begin
        if (pos_rd_ok) begin
          status_d = plp_pkg::ST_OK;
          code_d   = rd_entry.code;
          price_d  = rd_entry.price;
          do_del   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // count update
  always_comb begin
    cnt_d = cnt_q;
    if (accept && do_ins) begin
      cnt_d = cnt_q + plp_pkg::CNT_W'(1);
    end else if (accept && do_del) begin
      cnt_d = cnt_q - plp_pkg::CNT_W'(1);
    end
  end

  // per-cell select: open a gap on insert, close it on delete
  always_comb begin
    for (int i = 0; i < plp_pkg::DEPTH; i++) begin
      cell_op[i] = plp_pkg::OP_HOLD;
      if (accept && do_ins) begin
        if (plp_pkg::IDX_W'(i) == idx) begin
          cell_op[i] = plp_pkg::OP_LOAD;
        end else if (plp_pkg::IDX_W'(i) > idx) begin
          cell_op[i] = plp_pkg::OP_FROM_PREV;
        end
      end else if (accept && do_del) begin
        if (plp_pkg::IDX_W'(i) >= idx) begin
          cell_op[i] = plp_pkg::OP_FROM_NEXT;
        end
      end
    end
  end

  // slot chain
  for (genvar g = 0; g < plp_pkg::DEPTH; g++) begin : g_cell
    plp_pkg::entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = cell_q[g-1];
    end
    if (g == plp_pkg::DEPTH - 1) begin : g_last
      assign next_e = cell_q[g];
    end else begin : g_inner
      assign next_e = cell_q[g+1];
    end
    plp_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .new_i   (new_entry),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (cell_q[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      code_q   <= code_d;
      price_q  <= price_d;
      count_q  <= 5'(cnt_d);
    end
  end

  assign in_stall_o        = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign item_code_o       = code_q;
  assign item_price_bits_o = price_q;
  assign entry_count_o     = count_q;

  `ASSERT_CLK(a_cnt_range, cnt_q <= plp_pkg::CNT_W'(plp_pkg::DEPTH), "count above capacity")
  `ASSERT_IMPL(a_ins_count, accept && do_ins, ##1 cnt_q == $past(cnt_q) + plp_pkg::CNT_W'(1), "insert did not grow count")
  `ASSERT_IMPL(a_del_count, accept && do_del, ##1 cnt_q == $past(cnt_q) - plp_pkg::CNT_W'(1), "delete did not shrink count")
  `ASSERT_IMPL(a_err_zero, out_valid_q && status_q != plp_pkg::ST_OK, code_q == '0 && price_q == '0, "failed request returned data")

endmodule

`default_nettype wire

[test/positional_array_list_checker.sv]
module positional_array_list_checker
  import plp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel, observed
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  logic [1:0]         command_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] new_code_i,
  input  logic [31:0]        new_price_bits_i,
  // result channel, observed
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic [1:0]         status_i,
  input  logic signed [31:0] item_code_i,
  input  logic [31:0]        item_price_bits_i,
  input  logic [4:0]         entry_count_i,
  // to the stimulus side
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 list_len_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] code;
    logic [31:0] price;
    logic [4:0]  count;
  } list_result_t;

  // shadow copy of the list, compacted at slots 0 .. shadow_len-1
  logic [31:0]  shadow_code [DEPTH];
  logic [31:0]  shadow_price[DEPTH];
  int unsigned  shadow_len = 0;

  list_result_t results_due[$];
  int           mismatches = 0;
  int           due_count = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_count;
  assign list_len_o   = int'(shadow_len);

  // apply one request to the shadow list and queue the result it must give
  task automatic predict_request(input logic [1:0] cmd, input logic [4:0] pos_bits,
                                 input logic [31:0] code, input logic [31:0] price);
    list_result_t res;
    int unsigned  pos;
    int unsigned  i;
    pos       = pos_bits;
    res.status = ST_BADPOS;
    res.code   = '0;
    res.price  = '0;
    case (cmd)
      CMD_QUERY: begin
        if (pos >= 1 && pos <= shadow_len) begin
          res.code   = shadow_code[pos-1];
          res.price  = shadow_price[pos-1];
          res.status = ST_OK;
        end
      end
      CMD_INSERT: begin
        // full check wins over the position check
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (pos >= 1 && pos <= shadow_len + 1) begin
          for (i = shadow_len; i >= pos; i--) begin
            shadow_code[i]  = shadow_code[i-1];
            shadow_price[i] = shadow_price[i-1];
          end
          shadow_code[pos-1]  = code;
          shadow_price[pos-1] = price;
          shadow_len++;
          res.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (pos >= 1 && pos <= shadow_len) begin
          res.code  = shadow_code[pos-1];
          res.price = shadow_price[pos-1];
          for (i = pos - 1; i + 1 < shadow_len; i++) begin
            shadow_code[i]  = shadow_code[i+1];
            shadow_price[i] = shadow_price[i+1];
          end
          shadow_len--;
          res.status = ST_OK;
        end
      end
      default: ; // unknown command: bad request, list untouched
    endcase
    res.count = shadow_len[4:0];
    results_due.push_back(res);
  endtask

  // compare one delivered result with the oldest expectation
  task automatic check_result();
    list_result_t exp_res;
    if (results_due.size() == 0) begin
      $display("%0t: result with nothing outstanding: status %0d code %h price %h count %0d",
               $realtime, status_i, item_code_i, item_price_bits_i, entry_count_i);
      mismatches++;
    end else begin
      exp_res = results_due.pop_front();
      if (status_i !== exp_res.status) begin
        $display("%0t: status expected %0d, actual %0d", $realtime, exp_res.status, status_i);
        mismatches++;
      end
      if (item_code_i !== exp_res.code) begin
        $display("%0t: item_code expected %h, actual %h", $realtime, exp_res.code, item_code_i);
        mismatches++;
      end
      if (item_price_bits_i !== exp_res.price) begin
        $display("%0t: item_price_bits expected %h, actual %h",
                 $realtime, exp_res.price, item_price_bits_i);
        mismatches++;
      end
      if (entry_count_i !== exp_res.count) begin
        $display("%0t: entry_count expected %0d, actual %0d",
                 $realtime, exp_res.count, entry_count_i);
        mismatches++;
      end
    end
  endtask

  // inputs only move at the rising edge, so the falling edge sees settled values
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && !req_stall_i)
        predict_request(command_i, position_i, new_code_i, new_price_bits_i);
      if (res_valid_i && !res_stall_i)
        check_result();
      due_count = results_due.size();
    end
  end

endmodule

[test/positional_array_list_test.sv]
module positional_array_list_test;
  import plp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         REQUEST_TARGET = 750;
  localparam int         STALL_LIMIT    = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         command_i;
  logic [4:0]         position_i;
  logic signed [31:0] new_code_i;
  logic [31:0]        new_price_bits_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] item_code_o;
  logic [31:0]        item_price_bits_o;
  logic [4:0]         entry_count_o;

  int fail_count;
  int pending;
  int list_len;

  bit burst_mode = 1'b0;
  int idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  positional_array_list i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .position_i        (position_i),
    .new_code_i        (new_code_i),
    .new_price_bits_i  (new_price_bits_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .item_code_o       (item_code_o),
    .item_price_bits_o (item_price_bits_o),
    .entry_count_o     (entry_count_o)
  );

  positional_array_list_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (in_valid_i),
    .req_stall_i       (in_stall_o),
    .command_i         (command_i),
    .position_i        (position_i),
    .new_code_i        (new_code_i),
    .new_price_bits_i  (new_price_bits_i),
    .res_valid_i       (out_valid_o),
    .res_stall_i       (out_stall_i),
    .status_i          (status_o),
    .item_code_i       (item_code_o),
    .item_price_bits_i (item_price_bits_o),
    .entry_count_i     (entry_count_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .list_len_o        (list_len)
  );

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // command mix leans toward growing or shrinking the list
  function automatic logic [1:0] pick_command(bit growing);
    int r;
    r = $urandom_range(99);
    if (r < 4)  return CMD_UNUSED;
    if (r < 19) return CMD_QUERY;
    if (growing) return (r < 79) ? CMD_INSERT : CMD_DELETE;
    return (r < 79) ? CMD_DELETE : CMD_INSERT;
  endfunction

  // mostly a position that exists, sometimes any 5-bit value
  function automatic logic [4:0] pick_position(logic [1:0] cmd, int len);
    int last_pos;
    last_pos = (cmd == CMD_INSERT) ? len + 1 : len;
    if (last_pos >= 1 && last_pos <= 31 && $urandom_range(99) < 85)
      return 5'($urandom_range(last_pos, 1));
    return 5'($urandom_range(31));
  endfunction

  // present one request and hold it until taken; called at a rising edge
  task automatic send_request(input logic [1:0] cmd, input logic [4:0] pos,
                              input logic [31:0] code, input logic [31:0] price);
    int gap;
    bit taken;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    position_i       <= pos;
    new_code_i       <= code;
    new_price_bits_i <= price;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // result side back-pressure, with quiet stretches
  int stall_left = 0;
  int stall_cycle = 0;
  always @(posedge clk_i) begin
    stall_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ((stall_cycle / 300) % 4 != 3 && $urandom_range(3) == 0)
        stall_left = idle_len();
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    bit         growing;
    int         sent;
    logic [1:0] cmd;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    command_i        <= CMD_QUERY;
    position_i       <= '0;
    new_code_i       <= '0;
    new_price_bits_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, bad positions, data extremes, front/middle/end
    send_request(CMD_QUERY,  5'd1,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd0,  32'h0, 32'h0);
    send_request(CMD_UNUSED, 5'd1,  32'hffff_ffff, 32'hffff_ffff);
    send_request(CMD_INSERT, 5'd0,  32'h1234_5678, 32'h9abc_def0);
    send_request(CMD_INSERT, 5'd2,  32'h1234_5678, 32'h9abc_def0);
    send_request(CMD_INSERT, 5'd1,  32'h8000_0000, 32'h0000_0000);
    send_request(CMD_INSERT, 5'd2,  32'h7fff_ffff, 32'hffff_ffff);
    send_request(CMD_INSERT, 5'd1,  32'hffff_ffff, 32'h0000_0001);
    send_request(CMD_INSERT, 5'd2,  32'h0000_0000, 32'h8000_0000);
    send_request(CMD_INSERT, 5'd31, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(CMD_QUERY,  5'd0,  32'h0, 32'h0);
    send_request(CMD_QUERY,  5'd4,  32'h0, 32'h0);
    send_request(CMD_QUERY,  5'd5,  32'h0, 32'h0);
    send_request(CMD_QUERY,  5'd1,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd5,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd4,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd1,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd1,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd1,  32'h0, 32'h0);
    send_request(CMD_DELETE, 5'd1,  32'h0, 32'h0);
    send_request(CMD_UNUSED, 5'd31, 32'h8000_0000, 32'h0);

    // random: alternate filling and draining so full and empty lists recur
    growing = 1'b1;
    for (sent = 0; sent < REQUEST_TARGET; sent++) begin
      if (sent % 100 == 0)
        burst_mode = ($urandom_range(2) == 0);
      if (growing && list_len >= DEPTH && $urandom_range(5) == 0)
        growing = 1'b0;
      else if (!growing && list_len == 0 && $urandom_range(3) == 0)
        growing = 1'b1;
      else if ($urandom_range(59) == 0)
        growing = !growing;
      cmd = pick_command(growing);
      send_request(cmd, pick_position(cmd, list_len), pick_word(), pick_word());
    end
    in_valid_i <= 1'b0;

    // drain, then leave room for stray results to show up
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[positional_array_list.f]
+incdir+rtl/core
rtl/core/plp_pkg.sv
rtl/core/plp_cell.sv
rtl/core/positional_array_list.sv
test/positional_array_list_checker.sv
test/positional_array_list_test.sv
